// File: rtl/core/fr_pkg.sv
`default_nettype none
package fr_pkg;

    localparam int BUF_BYTES  = 1024;
    localparam int HDR_BYTES  = 10;
    localparam int POS_CAP    = BUF_BYTES + HDR_BYTES + 1;

    localparam int POS_W      = $clog2(POS_CAP + 1);
    localparam int CNT_W      = $clog2(BUF_BYTES + 1);
    localparam int IDX_W      = $clog2(2 * BUF_BYTES + 2);
    localparam int HIDX_W     = $clog2(HDR_BYTES);
    localparam int MEM_DEPTH  = 2 * BUF_BYTES;
    localparam int ADDR_W     = $clog2(MEM_DEPTH);

    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);
    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

    localparam logic [7:0] MAGIC0       = 8'h41;
    localparam logic [7:0] MAGIC1       = 8'h4D;
    localparam logic [7:0] VERSION_CODE = 8'h01;
    localparam int         FLAG_START   = 0;
    localparam int         FLAG_END     = 1;

    localparam logic [1:0] MODE_WRITE = 2'd0;
    localparam logic [1:0] MODE_LINK  = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    localparam logic [2:0] ST_TAKEN    = 3'd0;
    localparam logic [2:0] ST_CHUNK    = 3'd1;
    localparam logic [2:0] ST_COMPLETE = 3'd2;
    localparam logic [2:0] ST_REJECT   = 3'd3;
    localparam logic [2:0] ST_LINK     = 3'd4;
    localparam logic [2:0] ST_READ_OK  = 3'd5;
    localparam logic [2:0] ST_EMPTY    = 3'd6;

    typedef enum logic [1:0] {
        OP_BYTE,
        OP_LINK,
        OP_READ,
        OP_NOP
    } op_t;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] data_byte;
        logic       last_of_write;
        logic [9:0] read_index;
        logic       release_req;
    } frag_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  read_byte;
        logic        packet_ready;
        logic [10:0] packet_length;
        logic        frame_active;
        logic [10:0] bytes_assembled;
    } result_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] data_byte;
        logic       last_of_write;
        logic [9:0] read_index;
        logic       release_req;
    } cmd_t;

    function automatic op_t classify(input logic [1:0] mode);
        op_t op;
        unique case (mode)
            MODE_WRITE: op = OP_BYTE;
            MODE_LINK:  op = OP_LINK;
            MODE_READ:  op = OP_READ;
            default:    op = OP_NOP;
        endcase
        return op;
    endfunction

endpackage
`default_nettype wire

// File: rtl/core/fr_front.sv
`default_nettype none
module fr_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    output logic               full,
    input  wire fr_pkg::frag_t frag,
    output logic               cmd_valid,
    input  wire logic          cmd_take,
    output fr_pkg::cmd_t       cmd
);

    fr_pkg::cmd_t                     slot_reg [fr_pkg::CMDQ_DEPTH];
    logic [fr_pkg::CMDQ_PTR_W-1:0]    wr_ptr_reg;
    logic [fr_pkg::CMDQ_PTR_W-1:0]    rd_ptr_reg;
    logic [fr_pkg::CMDQ_CNT_W-1:0]    count_reg;
    logic [fr_pkg::CMDQ_CNT_W-1:0]    count_next;
    fr_pkg::cmd_t                     cmd_new;
    logic                             do_push;
    logic                             do_pop;

    assign full      = (count_reg == fr_pkg::CMDQ_CNT_W'(fr_pkg::CMDQ_DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign cmd       = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = cmd_take && cmd_valid;

    // decode the mode once here so the back end only switches on the op
    always_comb
    begin
        cmd_new.op            = fr_pkg::classify(frag.mode);
        cmd_new.data_byte     = frag.data_byte;
        cmd_new.last_of_write = frag.last_of_write;
        cmd_new.read_index    = frag.read_index;
        cmd_new.release_req   = frag.release_req;
    end

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= cmd_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/fr_outq.sv
`default_nettype none
module fr_outq (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           res_push,
    input  wire fr_pkg::result_t                res_data,
    output logic [fr_pkg::OUTQ_CNT_W-1:0]       level,
    output logic                                empty,
    input  wire logic                           pop,
    output fr_pkg::result_t                     result
);

    fr_pkg::result_t                  slot_reg [fr_pkg::OUTQ_DEPTH];
    logic [fr_pkg::OUTQ_PTR_W-1:0]    wr_ptr_reg;
    logic [fr_pkg::OUTQ_PTR_W-1:0]    rd_ptr_reg;
    logic [fr_pkg::OUTQ_CNT_W-1:0]    count_reg;
    logic [fr_pkg::OUTQ_CNT_W-1:0]    count_next;
    logic                             do_pop;

    assign level  = count_reg;
    assign empty  = (count_reg == '0);
    assign result = slot_reg[rd_ptr_reg];
    assign do_pop = pop && !empty;

    always_comb
    begin
        count_next = count_reg;
        if (res_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!res_push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_push)
        begin
            slot_reg[wr_ptr_reg] <= res_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (res_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/fr_back.sv
`default_nettype none
module fr_back (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cmd_valid,
    output logic                              cmd_take,
    input  wire fr_pkg::cmd_t                 cmd,
    input  wire logic [fr_pkg::OUTQ_CNT_W-1:0] outq_level,
    output logic                              res_push,
    output fr_pkg::result_t                   res_data
);

    localparam int POS_W  = fr_pkg::POS_W;
    localparam int CNT_W  = fr_pkg::CNT_W;
    localparam int IDX_W  = fr_pkg::IDX_W;
    localparam int ADDR_W = fr_pkg::ADDR_W;

    // header bytes, write position and frame state
    logic [7:0]        hdr_reg  [fr_pkg::HDR_BYTES];
    logic [7:0]        hdr_next [fr_pkg::HDR_BYTES];
    logic [POS_W-1:0]  position_reg, position_next;
    logic              bad_reg, bad_next;
    logic              active_reg, active_next;
    logic [15:0]       fid_reg, fid_next;
    logic [CNT_W-1:0]  total_reg, total_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              side_reg, side_next;
    logic              valid_reg, valid_next;
    logic [CNT_W-1:0]  length_reg, length_next;

    // execute-to-output stage
    logic              s1_valid_reg;
    fr_pkg::result_t   s1_res_reg, s1_res_next;
    logic              s1_hit_reg, s1_hit_next;

    logic [7:0]        mem [fr_pkg::MEM_DEPTH];
    logic [7:0]        rdata_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [ADDR_W-1:0] mem_raddr;

    logic [2:0]        status;
    logic [POS_W-1:0]  pos_inc;
    logic              byte_bad;
    logic [CNT_W-1:0]  base;
    logic [IDX_W-1:0]  idx;
    logic [7:0]        flags;
    logic [15:0]       fid_in, offset_in, total_in;
    logic [POS_W-1:0]  chunk;
    logic              is_start, start_ok;
    logic              a_act;
    logic [15:0]       a_id;
    logic [CNT_W-1:0]  a_tot;
    logic [CNT_W-1:0]  a_cnt;
    logic [CNT_W-1:0]  remain;
    logic [CNT_W-1:0]  new_cnt;
    logic              mismatch;
    logic              short_write;

    assign cmd_take = cmd_valid &&
        ((outq_level + fr_pkg::OUTQ_CNT_W'(s1_valid_reg)) <
         fr_pkg::OUTQ_CNT_W'(fr_pkg::OUTQ_DEPTH));

    // byte path
    always_comb
    begin
        hdr_next = hdr_reg;
        byte_bad = 1'b0;
        if (position_reg < POS_W'(fr_pkg::HDR_BYTES))
        begin
            hdr_next[position_reg[fr_pkg::HIDX_W-1:0]] = cmd.data_byte;
            byte_bad = ((position_reg == POS_W'(0)) && (cmd.data_byte != fr_pkg::MAGIC0)) ||
                       ((position_reg == POS_W'(1)) && (cmd.data_byte != fr_pkg::MAGIC1)) ||
                       ((position_reg == POS_W'(2)) && (cmd.data_byte != fr_pkg::VERSION_CODE));
        end
        pos_inc = (position_reg < POS_W'(fr_pkg::POS_CAP)) ? position_reg + 1'b1
                                                           : position_reg;
        base      = hdr_reg[3][fr_pkg::FLAG_START] ? '0 : count_reg;
        idx       = IDX_W'(base) + IDX_W'(position_reg - POS_W'(fr_pkg::HDR_BYTES));
        mem_we    = cmd_take && (cmd.op == fr_pkg::OP_BYTE) &&
                    (position_reg >= POS_W'(fr_pkg::HDR_BYTES)) && !bad_reg &&
                    (idx < IDX_W'(fr_pkg::BUF_BYTES));
        mem_waddr = ADDR_W'(idx) + (side_reg ? '0 : ADDR_W'(fr_pkg::BUF_BYTES));
        mem_raddr = ADDR_W'(cmd.read_index) + (side_reg ? ADDR_W'(fr_pkg::BUF_BYTES) : '0);
    end

    // commit checks on the header as it stands after this byte
    always_comb
    begin
        flags       = hdr_next[3];
        fid_in      = {hdr_next[5], hdr_next[4]};
        offset_in   = {hdr_next[7], hdr_next[6]};
        total_in    = {hdr_next[9], hdr_next[8]};
        chunk       = pos_inc - POS_W'(fr_pkg::HDR_BYTES);
        short_write = (pos_inc < POS_W'(fr_pkg::HDR_BYTES)) || bad_reg || byte_bad;
        is_start    = flags[fr_pkg::FLAG_START];
        start_ok    = (offset_in == 16'd0) && (total_in != 16'd0) &&
                      (total_in <= 16'(fr_pkg::BUF_BYTES));
        a_act       = is_start ? 1'b1 : active_reg;
        a_id        = is_start ? fid_in : fid_reg;
        a_tot       = is_start ? CNT_W'(total_in) : total_reg;
        a_cnt       = is_start ? '0 : count_reg;
        remain      = a_tot - a_cnt;
        mismatch    = !a_act || (fid_in != a_id) || (total_in != 16'(a_tot)) ||
                      (offset_in != 16'(a_cnt)) || (16'(chunk) > 16'(remain));
        new_cnt     = a_cnt + CNT_W'(chunk);
    end

    always_comb
    begin
        position_next = position_reg;
        bad_next      = bad_reg;
        active_next   = active_reg;
        fid_next      = fid_reg;
        total_next    = total_reg;
        count_next    = count_reg;
        side_next     = side_reg;
        valid_next    = valid_reg;
        length_next   = length_reg;
        status        = fr_pkg::ST_TAKEN;
        s1_hit_next   = 1'b0;
        unique case (cmd.op)
            fr_pkg::OP_BYTE:
            begin
                if (!cmd.last_of_write)
                begin
                    position_next = pos_inc;
                    bad_next      = bad_reg || byte_bad;
                end
                else
                begin
                    position_next = '0;
                    bad_next      = 1'b0;
                    status        = fr_pkg::ST_REJECT;
                    active_next   = 1'b0;
                    fid_next      = '0;
                    total_next    = '0;
                    count_next    = '0;
                    if (!short_write && !(is_start && !start_ok) && !mismatch)
                    begin
                        if (!flags[fr_pkg::FLAG_END])
                        begin
                            status      = fr_pkg::ST_CHUNK;
                            active_next = a_act;
                            fid_next    = a_id;
                            total_next  = a_tot;
                            count_next  = new_cnt;
                        end
                        else if (new_cnt == a_tot)
                        begin
                            status      = fr_pkg::ST_COMPLETE;
                            side_next   = !side_reg;
                            valid_next  = 1'b1;
                            length_next = a_tot;
                        end
                    end
                end
            end
            fr_pkg::OP_LINK:
            begin
                position_next = '0;
                bad_next      = 1'b0;
                active_next   = 1'b0;
                fid_next      = '0;
                total_next    = '0;
                count_next    = '0;
                status        = fr_pkg::ST_LINK;
            end
            fr_pkg::OP_READ:
            begin
                if (valid_reg)
                begin
                    status      = fr_pkg::ST_READ_OK;
                    s1_hit_next = (CNT_W'(cmd.read_index) < length_reg) &&
                                  (32'(cmd.read_index) < fr_pkg::BUF_BYTES);
                    if (cmd.release_req)
                    begin
                        valid_next = 1'b0;
                    end
                end
                else
                begin
                    status = fr_pkg::ST_EMPTY;
                end
            end
            fr_pkg::OP_NOP:
            begin
                status = fr_pkg::ST_TAKEN;
            end
            default:
            begin
                status = fr_pkg::ST_TAKEN;
            end
        endcase

        s1_res_next.status          = status;
        s1_res_next.read_byte       = '0;
        s1_res_next.packet_ready    = valid_next;
        s1_res_next.packet_length   = valid_next ? 11'(length_next) : 11'd0;
        s1_res_next.frame_active    = active_next;
        s1_res_next.bytes_assembled = 11'(count_next);
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= cmd.data_byte;
        end
        rdata_reg <= mem[mem_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            hdr_reg    <= hdr_next;
            s1_res_reg <= s1_res_next;
            s1_hit_reg <= s1_hit_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg <= '0;
            bad_reg      <= 1'b0;
            active_reg   <= 1'b0;
            fid_reg      <= '0;
            total_reg    <= '0;
            count_reg    <= '0;
            side_reg     <= 1'b0;
            valid_reg    <= 1'b0;
            length_reg   <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= cmd_take;
            if (cmd_take)
            begin
                position_reg <= position_next;
                bad_reg      <= bad_next;
                active_reg   <= active_next;
                fid_reg      <= fid_next;
                total_reg    <= total_next;
                count_reg    <= count_next;
                side_reg     <= side_next;
                valid_reg    <= valid_next;
                length_reg   <= length_next;
            end
        end
    end

    // read data joins the result in the cycle after execute
    always_comb
    begin
        res_push           = s1_valid_reg;
        res_data           = s1_res_reg;
        res_data.read_byte = s1_hit_reg ? rdata_reg : 8'd0;
    end

endmodule
`default_nettype wire

// File: rtl/core/fragment_reassembler.sv
// channel   | direction | handshake       | payload
// ----------+-----------+-----------------+-----------------------------
// frag      | in        | push / full     | fr_pkg::frag_t
// result    | out       | pop / empty     | fr_pkg::result_t
//
// one item per cycle sustained while the output queue drains; one result per item
// an input transfer reaches the shown result through the command queue,
// execute, then the registered packet memory read joining the output queue
// the execute stage stalls when the output queue and the result in flight fill four entries
// reset clears all control state; the packet memory is not cleared
// full rises when the four-entry command queue is full
`default_nettype none
module fragment_reassembler (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    output logic                 full,
    input  wire fr_pkg::frag_t   frag,
    output logic                 empty,
    input  wire logic            pop,
    output fr_pkg::result_t      result
);

    logic                             cmd_valid;
    logic                             cmd_take;
    fr_pkg::cmd_t                     cmd;
    logic [fr_pkg::OUTQ_CNT_W-1:0]    outq_level;
    logic                             res_push;
    fr_pkg::result_t                  res_data;

    fr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .frag      (frag),
        .cmd_valid (cmd_valid),
        .cmd_take  (cmd_take),
        .cmd       (cmd)
    );

    fr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_take   (cmd_take),
        .cmd        (cmd),
        .outq_level (outq_level),
        .res_push   (res_push),
        .res_data   (res_data)
    );

    fr_outq u_outq (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_push (res_push),
        .res_data (res_data),
        .level    (outq_level),
        .empty    (empty),
        .pop      (pop),
        .result   (result)
    );

    a_no_outq_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(res_push && (outq_level == fr_pkg::OUTQ_CNT_W'(fr_pkg::OUTQ_DEPTH)) && !pop))
        else $error("output queue overflow");

    a_take_needs_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_take |-> cmd_valid)
        else $error("command taken from empty queue");

    a_length_only_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !result.packet_ready) |-> (result.packet_length == 11'd0))
        else $error("packet length without waiting packet");

    a_read_byte_only_on_read: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (result.read_byte != 8'd0)) |-> (result.status == fr_pkg::ST_READ_OK))
        else $error("read byte outside a read");

endmodule
`default_nettype wire
